// File: rtl/ittx_pkg.sv
// shared types, codes and constants of the ir tag pulse width transmitter
package ittx_pkg;

	localparam int FRAME_BYTES_DEF = 3;

	localparam logic [1:0] KIND_SHOT  = 2'd0;
	localparam logic [1:0] KIND_MSG   = 2'd1;
	localparam logic [1:0] KIND_PULSE = 2'd2;

	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_EVENT = 2'd2;

	localparam logic [2:0] REG_HEADER_PERIOD = 3'd0;
	localparam logic [2:0] REG_ONE_PERIOD    = 3'd1;
	localparam logic [2:0] REG_ZERO_PERIOD   = 3'd2;
	localparam logic [2:0] REG_GAP_PERIOD    = 3'd3;
	localparam logic [2:0] REG_EMITTER_LEVEL = 3'd4;
	localparam logic [2:0] REG_OWN_PLAYER    = 3'd5;
	localparam logic [2:0] REG_OWN_TEAM      = 3'd6;
	localparam logic [2:0] REG_SHOT_BITS     = 3'd7;

	localparam logic [15:0] HEADER_PERIOD_RST = 16'd2400;
	localparam logic [15:0] ONE_PERIOD_RST    = 16'd1200;
	localparam logic [15:0] ZERO_PERIOD_RST   = 16'd600;
	localparam logic [15:0] GAP_PERIOD_RST    = 16'd600;
	localparam logic [7:0]  EMITTER_LEVEL_RST = 8'd255;
	localparam logic [6:0]  OWN_PLAYER_RST    = 7'd0;
	localparam logic [1:0]  OWN_TEAM_RST      = 2'd0;
	localparam logic [4:0]  SHOT_BITS_RST     = 5'd14;

	localparam logic [4:0] SHOT_MAX_BITS = 5'd16;
	localparam int         MSG_BITS_CAP  = 24;

	localparam int DAMAGE_LEVELS = 15;
	localparam logic [7:0] DAMAGE_BOUNDS [DAMAGE_LEVELS] = '{
		8'd2, 8'd3, 8'd5, 8'd6, 8'd9, 8'd14, 8'd16, 8'd19,
		8'd23, 8'd28, 8'd33, 8'd38, 8'd45, 8'd58, 8'd88
	};

	typedef struct packed {
		logic [15:0] header_period;
		logic [15:0] one_period;
		logic [15:0] zero_period;
		logic [15:0] gap_period;
		logic [7:0]  emitter_level;
		logic [6:0]  own_player;
		logic [1:0]  own_team;
		logic [4:0]  shot_bits;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic       was_on;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [4:0] nbits;
	} cmd_t;

	typedef struct packed {
		logic        pulse_start;
		logic        pulse_level;
		logic [15:0] pulse_length;
		logic [7:0]  power_out;
		logic        frame_done;
	} res_t;

	function automatic logic [3:0] quantise_damage(input logic [7:0] damage);
		logic [3:0] code;
		code = 4'd0;
		for (int i = 0; i < DAMAGE_LEVELS; i++) begin
			if (damage >= DAMAGE_BOUNDS[i]) begin
				code = 4'(i + 1);
			end
		end
		return code;
	endfunction

endpackage

// File: rtl/ittx_ifs.sv
// request and pulse command channel interfaces
interface ittx_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] damage;
	logic       was_on;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;
	logic [4:0] bit_count;

	modport source (
		output valid, kind, damage, was_on, first_byte, second_byte, third_byte, bit_count,
		input  ready
	);
	modport sink (
		input  valid, kind, damage, was_on, first_byte, second_byte, third_byte, bit_count,
		output ready
	);
endinterface

interface ittx_pls_if;
	logic        valid;
	logic        ready;
	logic        pulse_start;
	logic        pulse_level;
	logic [15:0] pulse_length;
	logic [7:0]  power_out;
	logic        frame_done;

	modport source (
		output valid, pulse_start, pulse_level, pulse_length, power_out, frame_done,
		input  ready
	);
	modport sink (
		input  valid, pulse_start, pulse_level, pulse_length, power_out, frame_done,
		output ready
	);
endinterface

// File: rtl/ittx_front.sv
// front end: accepts requests and events and classifies them into commands
module ittx_front #(
	parameter int FRAME_BYTES = ittx_pkg::FRAME_BYTES_DEF
) (
	ittx_req_if.sink        req,
	input  ittx_pkg::cfg_t  cfg,
	input  logic            full,
	output logic            push,
	output ittx_pkg::cmd_t  cmd
);
	import ittx_pkg::*;

	localparam int         MSG_MAX_INT = (FRAME_BYTES * 8 < MSG_BITS_CAP) ?
		FRAME_BYTES * 8 : MSG_BITS_CAP;
	localparam logic [4:0] MSG_MAX     = 5'(MSG_MAX_INT);

	logic [3:0] code;

	assign req.ready = !full;
	assign push      = req.valid && !full;
	assign code      = quantise_damage(req.damage);

	always_comb begin
		cmd        = '0;
		cmd.was_on = req.was_on;
		case (req.kind)
			KIND_SHOT: begin
				cmd.op    = OP_LOAD;
				cmd.byte0 = {1'b0, cfg.own_player};
				cmd.byte1 = {cfg.own_team, code, 2'b00};
				cmd.nbits = (cfg.shot_bits > SHOT_MAX_BITS) ? SHOT_MAX_BITS : cfg.shot_bits;
			end
			KIND_MSG: begin
				cmd.op    = OP_LOAD;
				cmd.byte0 = req.first_byte;
				cmd.byte1 = req.second_byte;
				cmd.byte2 = req.third_byte;
				cmd.nbits = (req.bit_count > MSG_MAX) ? MSG_MAX : req.bit_count;
			end
			KIND_PULSE: begin
				cmd.op = OP_EVENT;
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
	end

endmodule

// File: rtl/ittx_fifo.sv
// two-entry command queue between front and back end
module ittx_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ittx_pkg::cmd_t  wr_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output ittx_pkg::cmd_t  rd_cmd
);
	import ittx_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/ittx_back.sv
// back end: frame state, pulse sequencing and output register
module ittx_back #(
	parameter int FRAME_BYTES = ittx_pkg::FRAME_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ittx_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	input  ittx_pkg::cmd_t  cmd,
	output logic            pop,
	ittx_pls_if.source      pls
);
	import ittx_pkg::*;

	localparam int IDXW = $clog2(FRAME_BYTES);

	logic [7:0]      bytes_q [FRAME_BYTES];
	logic [4:0]      bits_sent_q;
	logic [4:0]      frame_bits_q;
	logic            header_q;
	logic            out_valid_q;
	res_t            res_q;

	logic [IDXW-1:0] byte_idx;
	logic            cur_bit;
	res_t            res;
	logic            send_bit;

	assign pop      = cmd_valid && (!out_valid_q || pls.ready);
	assign byte_idx = IDXW'(bits_sent_q[4:3]);
	assign cur_bit  = bytes_q[byte_idx][3'd7 - bits_sent_q[2:0]];
	assign send_bit = (cmd.op == OP_EVENT) && !header_q && (bits_sent_q < frame_bits_q)
		&& !cmd.was_on;

	always_comb begin
		res = '0;
		case (cmd.op)
			OP_LOAD: begin
				res.pulse_start  = 1'b1;
				res.pulse_level  = 1'b1;
				res.pulse_length = cfg.header_period;
				res.power_out    = cfg.emitter_level;
			end
			OP_EVENT: begin
				if (header_q || ((bits_sent_q < frame_bits_q) && cmd.was_on)) begin
					res.pulse_start  = 1'b1;
					res.pulse_length = cfg.gap_period;
				end else if (bits_sent_q >= frame_bits_q) begin
					res.frame_done = 1'b1;
				end else begin
					res.pulse_start  = 1'b1;
					res.pulse_level  = 1'b1;
					res.pulse_length = cur_bit ? cfg.one_period : cfg.zero_period;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				bytes_q[i] <= 8'd0;
			end
			bits_sent_q  <= 5'd0;
			frame_bits_q <= 5'd0;
			header_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (pls.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && (cmd.op == OP_LOAD)) begin
				for (int i = 0; i < FRAME_BYTES; i++) begin
					if (i == 0) begin
						bytes_q[i] <= cmd.byte0;
					end else if (i == 1) begin
						bytes_q[i] <= cmd.byte1;
					end else if (i == 2) begin
						bytes_q[i] <= cmd.byte2;
					end else begin
						bytes_q[i] <= 8'd0;
					end
				end
				bits_sent_q  <= 5'd0;
				frame_bits_q <= cmd.nbits;
				header_q     <= 1'b1;
			end else if (pop && (cmd.op == OP_EVENT)) begin
				if (header_q) begin
					header_q <= 1'b0;
				end else if (send_bit) begin
					bits_sent_q <= bits_sent_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign pls.valid        = out_valid_q;
	assign pls.pulse_start  = res_q.pulse_start;
	assign pls.pulse_level  = res_q.pulse_level;
	assign pls.pulse_length = res_q.pulse_length;
	assign pls.power_out    = res_q.power_out;
	assign pls.frame_done   = res_q.frame_done;

endmodule

// File: rtl/ir_tag_pulse_width_transmitter.sv
// top level of the ir tag pulse width transmitter
// an accepted transaction passes through the queue and then the output register before its result is valid
// throughput: one transaction per cycle while the output is not stalled
// a two-entry queue lets the front keep accepting, until it fills, while the output stalls
// reset clears frame state and queue and loads the register defaults
module ir_tag_pulse_width_transmitter #(
	parameter int FRAME_BYTES = ittx_pkg::FRAME_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	ittx_req_if.sink    req,
	ittx_pls_if.source  pls
);
	import ittx_pkg::*;

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic push;
	logic full;
	logic pop;
	logic not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_period <= HEADER_PERIOD_RST;
			cfg_q.one_period    <= ONE_PERIOD_RST;
			cfg_q.zero_period   <= ZERO_PERIOD_RST;
			cfg_q.gap_period    <= GAP_PERIOD_RST;
			cfg_q.emitter_level <= EMITTER_LEVEL_RST;
			cfg_q.own_player    <= OWN_PLAYER_RST;
			cfg_q.own_team      <= OWN_TEAM_RST;
			cfg_q.shot_bits     <= SHOT_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_PERIOD: cfg_q.header_period <= cfg_data;
				REG_ONE_PERIOD:    cfg_q.one_period    <= cfg_data;
				REG_ZERO_PERIOD:   cfg_q.zero_period   <= cfg_data;
				REG_GAP_PERIOD:    cfg_q.gap_period    <= cfg_data;
				REG_EMITTER_LEVEL: cfg_q.emitter_level <= cfg_data[7:0];
				REG_OWN_PLAYER:    cfg_q.own_player    <= cfg_data[6:0];
				REG_OWN_TEAM:      cfg_q.own_team      <= cfg_data[1:0];
				REG_SHOT_BITS:     cfg_q.shot_bits     <= cfg_data[4:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	ittx_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.req  (req),
		.cfg  (cfg_q),
		.full (full),
		.push (push),
		.cmd  (front_cmd)
	);

	ittx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (front_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_cmd    (queue_cmd)
	);

	ittx_back #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (not_empty),
		.cmd       (queue_cmd),
		.pop       (pop),
		.pls       (pls)
	);

endmodule
